// File: sv/mlr_pkg.sv
package mlr_pkg;

	localparam int COORD_BITS  = 11;
	localparam int DELTA_BITS  = COORD_BITS + 1;
	localparam int ERR_BITS    = COORD_BITS + 3;
	localparam int COLOUR_BITS = 32;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	typedef struct packed {
		logic                   action;
		logic [COORD_BITS-1:0]  start_x;
		logic [COORD_BITS-1:0]  start_y;
		logic [COORD_BITS-1:0]  end_x;
		logic [COORD_BITS-1:0]  end_y;
		logic [COLOUR_BITS-1:0] colour;
	} cmd_t;

	typedef struct packed {
		logic [COORD_BITS-1:0]  x;
		logic [COORD_BITS-1:0]  y;
		logic [COLOUR_BITS-1:0] colour;
		logic                   valid;
		logic                   last;
	} pix_t;

endpackage

// File: sv/mlr_core.sv
module mlr_core import mlr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  cmd_t cmd,
	output pix_t pix
);

	logic [COORD_BITS-1:0]  major_pos_q;
	logic [COORD_BITS-1:0]  minor_pos_q;
	logic [COORD_BITS-1:0]  major_end_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic [DELTA_BITS-1:0]  major_delta_q;
	logic [DELTA_BITS-1:0]  minor_delta_q;
	logic                   swapped_q;
	logic                   major_neg_q;
	logic                   minor_neg_q;
	logic                   active_q;
	logic [COLOUR_BITS-1:0] colour_q;

	// start decode
	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;
	logic                  xneg;
	logic                  yneg;
	logic                  swap;
	logic                  zero_len;
	logic [DELTA_BITS-1:0] st_major_delta;
	logic [DELTA_BITS-1:0] st_minor_delta;
	logic signed [ERR_BITS-1:0] st_err;

	assign xneg     = cmd.end_x < cmd.start_x;
	assign yneg     = cmd.end_y < cmd.start_y;
	assign adx      = xneg ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
	assign ady      = yneg ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
	assign swap     = ady > adx;
	assign zero_len = (adx == '0) && (ady == '0);
	assign st_major_delta = DELTA_BITS'(swap ? ady : adx);
	assign st_minor_delta = DELTA_BITS'(swap ? adx : ady);
	assign st_err = (ERR_BITS'(st_minor_delta) <<< 1) - ERR_BITS'(st_major_delta);

	// advance step
	logic signed [ERR_BITS-1:0] dm_e;
	logic signed [ERR_BITS-1:0] dmaj_e;
	logic                       minor_step;
	logic signed [ERR_BITS-1:0] adv_err;
	logic [COORD_BITS-1:0]      adv_minor;
	logic [COORD_BITS-1:0]      adv_major;
	logic                       adv_last;

	assign dm_e       = ERR_BITS'(minor_delta_q);
	assign dmaj_e     = ERR_BITS'(major_delta_q);
	assign minor_step = err_q > 0;
	assign adv_err    = minor_step ? err_q + ((dm_e - dmaj_e) <<< 1) : err_q + (dm_e <<< 1);
	assign adv_minor  = minor_step ? (minor_neg_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1)
		: minor_pos_q;
	assign adv_major  = major_neg_q ? major_pos_q - 1'b1 : major_pos_q + 1'b1;
	assign adv_last   = adv_major == major_end_q;

	always_comb begin
		pix = '0;
		if (cmd.action == ACT_START) begin
			if (!zero_len) begin
				pix.x      = cmd.start_x;
				pix.y      = cmd.start_y;
				pix.colour = cmd.colour;
				pix.valid  = 1'b1;
			end
		end else if (active_q) begin
			pix.x      = swapped_q ? adv_minor : adv_major;
			pix.y      = swapped_q ? adv_major : adv_minor;
			pix.colour = colour_q;
			pix.valid  = 1'b1;
			pix.last   = adv_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q   <= '0;
			minor_pos_q   <= '0;
			major_end_q   <= '0;
			err_q         <= '0;
			major_delta_q <= '0;
			minor_delta_q <= '0;
			swapped_q     <= 1'b0;
			major_neg_q   <= 1'b0;
			minor_neg_q   <= 1'b0;
			active_q      <= 1'b0;
			colour_q      <= '0;
		end else if (fire) begin
			if (cmd.action == ACT_START) begin
				colour_q <= cmd.colour;
				if (zero_len) begin
					active_q <= 1'b0;
				end else begin
					active_q      <= 1'b1;
					swapped_q     <= swap;
					major_pos_q   <= swap ? cmd.start_y : cmd.start_x;
					minor_pos_q   <= swap ? cmd.start_x : cmd.start_y;
					major_end_q   <= swap ? cmd.end_y : cmd.end_x;
					major_neg_q   <= swap ? yneg : xneg;
					minor_neg_q   <= swap ? xneg : yneg;
					major_delta_q <= st_major_delta;
					minor_delta_q <= st_minor_delta;
					err_q         <= st_err;
				end
			end else if (active_q) begin
				major_pos_q <= adv_major;
				minor_pos_q <= adv_minor;
				err_q       <= adv_err;
				if (adv_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pix.valid && pix.last |=> !active_q)
		else $error("line still active after its end pixel");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.valid |-> pix.x == '0 && pix.y == '0 && pix.colour == '0 && !pix.last)
		else $error("empty beat carries nonzero fields");

	a_err_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> err_q <= (dm_e <<< 1) && err_q > -(dmaj_e <<< 1))
		else $error("decision term out of range");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd.action == ACT_ADVANCE && !active_q |=> $stable(major_pos_q) && !active_q)
		else $error("advance while idle changed state");
`endif

endmodule

// File: sv/midpoint_line_rasterizer.sv
// pipeline: a command beat is registered in cmd_s1, then its result beat in res_q
// throughput: one command beat and one pixel beat per cycle while res_stall
// is low; one add and sign test of the decision term per pixel sets the cycle
// reset: arst_n clears the line state to idle and empties both pipeline registers
module midpoint_line_rasterizer import mlr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  logic                   action,
	input  logic [COORD_BITS-1:0]  start_x,
	input  logic [COORD_BITS-1:0]  start_y,
	input  logic [COORD_BITS-1:0]  end_x,
	input  logic [COORD_BITS-1:0]  end_y,
	input  logic [COLOUR_BITS-1:0] colour,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic [COORD_BITS-1:0]  pixel_x,
	output logic [COORD_BITS-1:0]  pixel_y,
	output logic [COLOUR_BITS-1:0] pixel_colour,
	output logic                   pixel_valid,
	output logic                   last_pixel
);

	cmd_t cmd_s1;
	logic valid_s1;
	pix_t pix;
	pix_t res_q;
	logic res_valid_q;
	logic res_free;
	logic fire;
	logic take;

	assign res_free  = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && res_free;
	assign cmd_stall = valid_s1 && !res_free;
	assign take      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take || fire) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.action  <= action;
			cmd_s1.start_x <= start_x;
			cmd_s1.start_y <= start_y;
			cmd_s1.end_x   <= end_x;
			cmd_s1.end_y   <= end_y;
			cmd_s1.colour  <= colour;
		end
	end

	mlr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.pix    (pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= pix;
		end
	end

	assign res_valid    = res_valid_q;
	assign pixel_x      = res_q.x;
	assign pixel_y      = res_q.y;
	assign pixel_colour = res_q.colour;
	assign pixel_valid  = res_q.valid;
	assign last_pixel   = res_q.last;

endmodule
